[rtl/bls_pkg.sv]
// ----------------------------------------------------------------------------
// bls_pkg
// Request codes and field widths shared by the bounded list stack.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [COUNT_W-1:0] count_out_t;

    localparam mode_t OP_PUSH   = 3'd0;
    localparam mode_t OP_POP    = 3'd1;
    localparam mode_t OP_REMOVE = 3'd2;
    localparam mode_t OP_GET    = 3'd3;
    localparam mode_t OP_RESET  = 3'd4;

endpackage

[rtl/bounded_list_stack.sv]
// ----------------------------------------------------------------------------
// bounded_list_stack
// Ordered list of up to CAPACITY entries held in a single-port-read,
// single-port-write synchronous memory, with a fill count.
//
// Request channel: mode, item_value, position with in_valid / in_stall.
// Result channel: read_value, ok, entry_count with out_valid / out_stall.
// One result per request; a request is taken only when no other request
// is in flight and the result register is free or being drained.
// Push, reset, unknown codes, pop on an empty list, get out of range and
// remove on an empty list: result in the cycle after the request.
// Pop and get otherwise: one memory read into mem_rdata_reg, then the result
// is registered from it in S_READ. Remove otherwise: one streaming pass reads
// each held entry once and writes every entry after the match one place down;
// the result is registered once the last held entry has been handled.
// Reset (rst_n low) empties the list and drops any pending result; memory
// contents are not cleared and need no clearing pass.
// While out_stall is high a valid result holds in the result register and no
// new request is taken.
// ----------------------------------------------------------------------------
module bounded_list_stack #(
    parameter int CAPACITY    = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bls_pkg::mode_t      mode,
    input  bls_pkg::value_t     item_value,
    input  bls_pkg::pos_t       position,
    output logic                out_valid,
    input  logic                out_stall,
    output bls_pkg::value_t     read_value,
    output logic                ok,
    output bls_pkg::count_out_t entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_RMV  = 2'd2;

    typedef logic [ENTRY_WIDTH-1:0] entry_t;

    entry_t entry_mem [CAPACITY];
    entry_t mem_rdata_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] pend_addr_reg, pend_addr_next;
    logic          pend_reg, pend_next;
    logic          found_reg, found_next;
    entry_t        key_reg, key_next;

    logic                out_valid_reg, out_valid_next;
    bls_pkg::value_t     read_value_reg, read_value_next;
    logic                ok_reg, ok_next;
    bls_pkg::count_out_t entry_count_reg, entry_count_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic   accept;
    entry_t in_entry;

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign in_entry = ENTRY_WIDTH'(item_value);

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_ptr_next      = rd_ptr_reg;
        pend_addr_next   = pend_addr_reg;
        pend_next        = pend_reg;
        found_next       = found_reg;
        key_next         = key_reg;
        out_valid_next   = out_valid_reg && out_stall;
        read_value_next  = read_value_reg;
        ok_next          = ok_reg;
        entry_count_next = entry_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = AW'(count_reg);
        mem_wdata        = in_entry;
        mem_raddr        = AW'(rd_ptr_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    read_value_next = '0;
                    ok_next         = 1'b0;
                    case (mode)
                        bls_pkg::OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg < CW'(CAPACITY))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                ok_next    = 1'b1;
                            end
                            entry_count_next = 7'(count_next);
                        end
                        bls_pkg::OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_raddr  = AW'(count_reg - CW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_valid_next   = 1'b1;
                                entry_count_next = 7'(count_reg);
                            end
                        end
                        bls_pkg::OP_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                key_next    = in_entry;
                                rd_ptr_next = '0;
                                pend_next   = 1'b0;
                                found_next  = 1'b0;
                                state_next  = S_RMV;
                            end
                            else
                            begin
                                out_valid_next   = 1'b1;
                                entry_count_next = 7'(count_reg);
                            end
                        end
                        bls_pkg::OP_GET:
                        begin
                            if ((32'(position) < 32'(count_reg)) &&
                                (32'(position) < 32'(CAPACITY)))
                            begin
                                mem_raddr  = AW'(position);
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_valid_next   = 1'b1;
                                entry_count_next = 7'(count_reg);
                            end
                        end
                        bls_pkg::OP_RESET:
                        begin
                            count_next       = '0;
                            ok_next          = 1'b1;
                            out_valid_next   = 1'b1;
                            entry_count_next = '0;
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            entry_count_next = 7'(count_reg);
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next   = 1'b1;
                read_value_next  = 32'(mem_rdata_reg);
                ok_next          = 1'b1;
                entry_count_next = 7'(count_reg);
                state_next       = S_IDLE;
            end
            S_RMV:
            begin
                // stream: read entry rd_ptr, handle entry read last cycle
                if (rd_ptr_reg < count_reg)
                begin
                    mem_raddr      = AW'(rd_ptr_reg);
                    rd_ptr_next    = rd_ptr_reg + CW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (found_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(pend_addr_reg - CW'(1));
                        mem_wdata = mem_rdata_reg;
                    end
                    else if (mem_rdata_reg == key_reg)
                    begin
                        found_next = 1'b1;
                    end
                    if (pend_addr_reg == count_reg - CW'(1))
                    begin
                        out_valid_next  = 1'b1;
                        read_value_next = '0;
                        ok_next         = found_next;
                        if (found_next)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        entry_count_next = 7'(count_next);
                        pend_next        = 1'b0;
                        state_next       = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= entry_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg      <= rd_ptr_next;
        pend_addr_reg   <= pend_addr_next;
        key_reg         <= key_next;
        read_value_reg  <= read_value_next;
        ok_reg          <= ok_next;
        entry_count_reg <= entry_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = read_value_reg;
    assign ok          = ok_reg;
    assign entry_count = entry_count_reg;

endmodule

[test/list_stack_checker.sv]
// ----------------------------------------------------------------------------
// list_stack_checker
// Watches both channels of the bounded list stack. Every accepted request is
// applied to a local copy of the list to work out its result, which is queued.
// Every accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module list_stack_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  bls_pkg::mode_t      mode,
    input  bls_pkg::value_t     item_value,
    input  bls_pkg::pos_t       position,
    input  logic                out_valid,
    input  logic                out_stall,
    input  bls_pkg::value_t     read_value,
    input  logic                ok,
    input  bls_pkg::count_out_t entry_count,
    output int                  mismatches,
    output int                  awaited
);

    typedef struct packed {
        bls_pkg::value_t     read_value;
        logic                ok;
        bls_pkg::count_out_t count;
    } list_result_t;

    bls_pkg::value_t held [CAPACITY];
    int              held_count = 0;
    list_result_t    pending_results [$];
    int              err_n = 0;

    function automatic list_result_t apply_list_op(bls_pkg::mode_t m, bls_pkg::value_t v,
                                                   bls_pkg::pos_t p);
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        case (m)
            bls_pkg::OP_PUSH:
            begin
                if (held_count < CAPACITY)
                begin
                    held[held_count] = v;
                    held_count++;
                    r.ok = 1'b1;
                end
            end
            bls_pkg::OP_POP:
            begin
                if (held_count > 0)
                begin
                    held_count--;
                    r.read_value = held[held_count];
                    r.ok = 1'b1;
                end
            end
            bls_pkg::OP_REMOVE:
            begin
                for (int i = 0; i < held_count; i++)
                    if (hit < 0 && held[i] == v)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int j = hit; j + 1 < held_count; j++)
                        held[j] = held[j + 1];
                    held_count--;
                    r.ok = 1'b1;
                end
            end
            bls_pkg::OP_GET:
            begin
                if (int'(p) < held_count)
                begin
                    r.read_value = held[p];
                    r.ok = 1'b1;
                end
            end
            bls_pkg::OP_RESET:
            begin
                held_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = bls_pkg::count_out_t'(held_count);
        return r;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        err_n++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            pending_results.delete();
            awaited <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    err_n++;
                    $display("%0t: unexpected result, expected none, actual %0h/%b/%0d",
                             $time, read_value, ok, entry_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.read_value)
                        report("read_value", want.read_value, read_value);
                    if (ok !== want.ok)
                        report("ok", 32'(want.ok), 32'(ok));
                    if (entry_count !== want.count)
                        report("entry_count", 32'(want.count), 32'(entry_count));
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_list_op(mode, item_value, position));
            mismatches <= err_n;
            awaited    <= pending_results.size();
        end
    end

endmodule

[test/tb_bounded_list_stack.sv]
// ----------------------------------------------------------------------------
// tb_bounded_list_stack
// Drives requests into the bounded list stack: a directed opening on the
// corner cases, then random segments that fill, drain and churn the list,
// with bursty requests, a wandering result stall and one long hold-off.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bounded_list_stack;

    localparam int             LIST_DEPTH       = 64;
    localparam int             RANDOM_REQUESTS  = 1600;
    localparam bls_pkg::mode_t FIRST_SPARE_MODE = bls_pkg::OP_RESET + 3'd1;
    localparam bls_pkg::mode_t LAST_SPARE_MODE  = '1;

    typedef enum {FILL_UP, DRAIN_DOWN, MIXED_OPS} load_profile_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    bls_pkg::mode_t      mode       = bls_pkg::OP_PUSH;
    bls_pkg::value_t     item_value = '0;
    bls_pkg::pos_t       position   = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    bls_pkg::value_t     read_value;
    logic                ok;
    bls_pkg::count_out_t entry_count;
    int                  mismatches;
    int                  awaited;

    int         burst_left = 1;
    bit         gaps_on    = 1'b1;

    bounded_list_stack #(
        .CAPACITY    (LIST_DEPTH),
        .ENTRY_WIDTH (bls_pkg::VALUE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .ok          (ok),
        .entry_count (entry_count)
    );

    list_stack_checker #(
        .CAPACITY (LIST_DEPTH)
    ) list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .ok          (ok),
        .entry_count (entry_count),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: stall phases of varying density, one long hold-off
    initial
    begin
        int phase_len;
        int stall_pct;
        int cycles;
        bit held_off;
        cycles   = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            phase_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (phase_len)
            begin
                @(posedge clk);
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                cycles++;
            end
            if (!held_off && cycles > 4000)
            begin
                @(posedge clk);
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
                held_off = 1'b1;
            end
        end
    end

    task automatic offer(bls_pkg::mode_t m, bls_pkg::value_t v, bls_pkg::pos_t p);
        in_valid   <= 1'b1;
        mode       <= m;
        item_value <= v;
        position   <= p;
        do @(posedge clk); while (in_stall);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited != 0);
    endtask

    function automatic bls_pkg::mode_t pick_mode(load_profile_t prof);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            return bls_pkg::mode_t'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
        case (prof)
            FILL_UP:
                if (roll < 77)      return bls_pkg::OP_PUSH;
                else if (roll < 82) return bls_pkg::OP_POP;
                else if (roll < 90) return bls_pkg::OP_REMOVE;
                else                return bls_pkg::OP_GET;
            DRAIN_DOWN:
                if (roll < 17)      return bls_pkg::OP_PUSH;
                else if (roll < 60) return bls_pkg::OP_POP;
                else if (roll < 80) return bls_pkg::OP_REMOVE;
                else                return bls_pkg::OP_GET;
            default:
                if (roll < 37)      return bls_pkg::OP_PUSH;
                else if (roll < 57) return bls_pkg::OP_POP;
                else if (roll < 77) return bls_pkg::OP_REMOVE;
                else if (roll < 97) return bls_pkg::OP_GET;
                else                return bls_pkg::OP_RESET;
        endcase
    endfunction

    initial
    begin
        load_profile_t   prof;
        bls_pkg::value_t pool [6];
        bls_pkg::value_t v;
        bls_pkg::pos_t   p;
        bls_pkg::mode_t  m;
        int              useful;
        int              seg_len;
        bit              use_pool;
        int              guard;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        offer(bls_pkg::OP_PUSH, '0, '0);
        offer(bls_pkg::OP_PUSH, '1, '1);
        offer(bls_pkg::OP_PUSH, 32'hA5A5_5A5A, '0);
        offer(bls_pkg::OP_GET, '1, 6'd0);
        offer(bls_pkg::OP_GET, '0, 6'd2);
        offer(bls_pkg::OP_GET, '0, 6'd3);
        offer(bls_pkg::OP_GET, '0, '1);
        offer(bls_pkg::OP_REMOVE, '1, '0);
        offer(bls_pkg::OP_REMOVE, 32'h1234_5678, '0);
        offer(bls_pkg::OP_POP, '0, '0);
        offer(bls_pkg::OP_POP, '0, '0);
        offer(bls_pkg::OP_POP, '0, '0);
        offer(bls_pkg::OP_REMOVE, '0, '0);
        offer(bls_pkg::OP_PUSH, 32'd1, '0);
        offer(bls_pkg::OP_PUSH, 32'd1, '0);
        offer(bls_pkg::OP_PUSH, 32'd7, '0);
        offer(bls_pkg::OP_REMOVE, 32'd1, '0);
        offer(bls_pkg::OP_GET, '0, 6'd0);
        offer(bls_pkg::OP_REMOVE, 32'd7, '0);
        offer(bls_pkg::OP_RESET, '1, '1);
        offer(bls_pkg::OP_GET, '0, 6'd0);
        for (int k = FIRST_SPARE_MODE; k <= LAST_SPARE_MODE; k++)
            offer(bls_pkg::mode_t'(k), '1, '1);
        wait_drained();

        // random segments
        useful = 0;
        while (useful < RANDOM_REQUESTS)
        begin
            case ($urandom_range(0, 2))
                0:       prof = FILL_UP;
                1:       prof = DRAIN_DOWN;
                default: prof = MIXED_OPS;
            endcase
            for (int k = 0; k < 6; k++)
                case ($urandom_range(0, 5))
                    0:       pool[k] = '0;
                    1:       pool[k] = '1;
                    default: pool[k] = bls_pkg::value_t'($urandom);
                endcase
            use_pool = ($urandom_range(0, 3) != 0);
            gaps_on  = ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 3) == 0)
                wait_drained();
            seg_len = $urandom_range(30, 150);
            repeat (seg_len)
            begin
                m = pick_mode(prof);
                if (use_pool && $urandom_range(0, 4) != 0)
                    v = pool[$urandom_range(0, 5)];
                else
                    v = bls_pkg::value_t'($urandom);
                if ($urandom_range(0, 1) == 1)
                    p = bls_pkg::pos_t'($urandom_range(0, 63));
                else
                    p = bls_pkg::pos_t'($urandom_range(0, 20));
                offer(m, v, p);
                if (m <= bls_pkg::OP_RESET)
                    useful++;
            end
        end

        in_valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (awaited != 0 && guard < 200000);
        repeat (LIST_DEPTH + 8) @(posedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[bounded_list_stack.f]
rtl/bls_pkg.sv
rtl/bounded_list_stack.sv
test/list_stack_checker.sv
test/tb_bounded_list_stack.sv
